FILE: sv/tss_pkg.sv
// Shared types, constants and helpers for the Taylor sine/cosine pipeline.
// No dependencies; every other file imports this package.
`default_nettype none

package tss_pkg;

    localparam int FRAC        = 40;          // internal fraction bits
    localparam int ANGLE_W     = 32;          // Q4.27 input angle
    localparam int ANGLE_FRAC  = 27;
    localparam int ANGLE_SHIFT = FRAC - ANGLE_FRAC;
    localparam int RESULT_W    = 32;          // Q2.30 result
    localparam int RESULT_FRAC = 30;
    localparam int RED_W       = 47;          // raised angle and reduction candidates
    localparam int HALF_W      = 23;          // multiplier split point
    localparam int MAG_W       = 2 * HALF_W;  // magnitude of terms, x^2 and products
    localparam int PROD_W      = 2 * MAG_W;   // exact product width
    localparam int SUM_W       = 48;          // running series sum

    localparam int SINE_TOP_DEGREE   = 9;
    localparam int COSINE_TOP_DEGREE = 10;

    localparam logic signed [RED_W-1:0] PI_Q      = RED_W'(64'h3243F6A8886);
    localparam logic signed [RED_W-1:0] TWO_PI_Q  = RED_W'(64'h6487ED5110B);
    localparam logic signed [RED_W-1:0] FOUR_PI_Q = RED_W'(64'h6487ED5110B * 2);
    localparam logic signed [RED_W-1:0] SIX_PI_Q  = RED_W'(64'h6487ED5110B * 3);

    localparam logic [MAG_W-1:0] ONE_Q    = MAG_W'(64'd1 << FRAC);
    localparam logic [MAG_W-1:0] X2_LIMIT = MAG_W'(64'd10 << FRAC);

    typedef enum logic {
        CMD_SINE   = 1'b0,
        CMD_COSINE = 1'b1
    } t_cmd;

    // One word in flight through the series steps. The current term is held
    // as sign and magnitude; pending marks a term not yet folded into sum.
    typedef struct packed {
        t_cmd                     cmd;
        logic [MAG_W-1:0]         x2;
        logic                     sign;
        logic [MAG_W-1:0]         mag;
        logic signed [SUM_W-1:0]  sum;
        logic                     pending;
    } t_item;

    function automatic logic signed [SUM_W-1:0] signed_term(input logic sign,
                                                            input logic [MAG_W-1:0] mag);
        logic signed [SUM_W-1:0] ext;
        ext = $signed(SUM_W'(mag));
        return sign ? -ext : ext;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tss_in_if.sv
// Input channel: valid/ready handshake carrying command and angle.
// Depends on tss_pkg.
`default_nettype none

interface tss_in_if import tss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output command, output angle, input ready);
    modport sink   (input valid, input command, input angle, output ready);
endinterface

`default_nettype wire

FILE: sv/tss_out_if.sv
// Output channel: valid/ready handshake carrying the series result.
// Depends on tss_pkg.
`default_nettype none

interface tss_out_if import tss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

FILE: sv/tss_mul.sv
// Two-stage unsigned fixed-point multiplier: split partial products, then
// sum and round to nearest at the internal fraction point. Uses tss_pkg.
`default_nettype none

module tss_mul import tss_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en_pp,
    input  wire logic             i_en_rnd,
    input  wire logic [MAG_W-1:0] i_a,
    input  wire logic [MAG_W-1:0] i_b,
    output logic      [MAG_W-1:0] o_p
);

    logic [MAG_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [MAG_W-1:0] n_ll, n_lh, n_hl, n_hh;
    logic [MAG_W-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [PROD_W-1:0] full;
    logic [MAG_W-1:0] n_p, r_p;

    always_comb begin
        a_lo = MAG_W'(i_a[HALF_W-1:0]);
        a_hi = MAG_W'(i_a[MAG_W-1:HALF_W]);
        b_lo = MAG_W'(i_b[HALF_W-1:0]);
        b_hi = MAG_W'(i_b[MAG_W-1:HALF_W]);
        n_ll = a_lo * b_lo;
        n_lh = a_lo * b_hi;
        n_hl = a_hi * b_lo;
        n_hh = a_hi * b_hi;
    end

    always_comb begin
        full = (PROD_W'(r_hh) << MAG_W) + (PROD_W'(r_lh) << HALF_W)
             + (PROD_W'(r_hl) << HALF_W) + PROD_W'(r_ll)
             + (PROD_W'(1) << (FRAC - 1));
        n_p  = full[FRAC +: MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_hh <= n_hh;
        end
        if (i_en_rnd) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: sv/tss_front.sv
// Front end: range reduction by whole turns, then x^2, then the first
// series term for sine or cosine. Uses tss_pkg, tss_in_if and tss_mul.
`default_nettype none

module tss_front import tss_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tss_in_if.sink    i_word,
    output t_item     o_item,
    output logic      o_valid,
    input  wire logic i_ready
);

    logic ld1, ld2, ld3;
    logic r1_v, r2_v, r3_v;
    t_cmd r1_cmd, r2_cmd, r3_cmd;
    logic signed [RED_W-1:0] x_in, p1, p2, p3, m1, m2, m3, n1_x;
    logic signed [RED_W-1:0] r1_x, r2_x, r3_x;
    logic [MAG_W-1:0] n2_mag, r2_mag, r3_mag;
    logic [MAG_W-1:0] x2;

    assign ld3 = !r3_v || i_ready;
    assign ld2 = !r2_v || ld3;
    assign ld1 = !r1_v || ld2;
    assign i_word.ready = ld1;

    // Stage 1: pick the first candidate that lands in [-pi, pi].
    always_comb begin
        x_in = RED_W'(i_word.angle) <<< ANGLE_SHIFT;
        p1   = x_in + TWO_PI_Q;
        p2   = x_in + FOUR_PI_Q;
        p3   = x_in + SIX_PI_Q;
        m1   = x_in - TWO_PI_Q;
        m2   = x_in - FOUR_PI_Q;
        m3   = x_in - SIX_PI_Q;
        priority if (x_in < -PI_Q) begin
            priority if (p1 >= -PI_Q) begin
                n1_x = p1;
            end else if (p2 >= -PI_Q) begin
                n1_x = p2;
            end else begin
                n1_x = p3;
            end
        end else if (x_in > PI_Q) begin
            priority if (m1 <= PI_Q) begin
                n1_x = m1;
            end else if (m2 <= PI_Q) begin
                n1_x = m2;
            end else begin
                n1_x = m3;
            end
        end else begin
            n1_x = x_in;
        end
    end

    assign n2_mag = MAG_W'(r1_x[RED_W-1] ? -r1_x : r1_x);

    tss_mul u_sq (
        .i_clk    (i_clk),
        .i_en_pp  (ld2),
        .i_en_rnd (ld3),
        .i_a      (n2_mag),
        .i_b      (n2_mag),
        .o_p      (x2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (ld1) r1_v <= i_word.valid;
            if (ld2) r2_v <= r1_v;
            if (ld3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_cmd <= t_cmd'(i_word.command);
            r1_x   <= n1_x;
        end
        if (ld2) begin
            r2_cmd <= r1_cmd;
            r2_x   <= r1_x;
            r2_mag <= n2_mag;
        end
        if (ld3) begin
            r3_cmd <= r2_cmd;
            r3_x   <= r2_x;
            r3_mag <= r2_mag;
        end
    end

    always_comb begin
        o_item.cmd     = r3_cmd;
        o_item.x2      = x2;
        o_item.pending = 1'b0;
        if (r3_cmd == CMD_SINE) begin
            o_item.sign = r3_x[RED_W-1];
            o_item.mag  = r3_mag;
            o_item.sum  = SUM_W'(r3_x);
        end else begin
            o_item.sign = 1'b0;
            o_item.mag  = ONE_Q;
            o_item.sum  = $signed(SUM_W'(ONE_Q));
        end
    end

    assign o_valid = r3_v;

endmodule

`default_nettype wire

FILE: sv/tss_step.sv
// One series step: fold the pending term into the sum, then form the next
// term as -(term * x^2) * 1/(n*(n-1)) over four stages. Uses tss_pkg, tss_mul.
`default_nettype none

module tss_step import tss_pkg::*; #(
    parameter int P_STEP      = 1,
    parameter int P_SINE_TOP  = SINE_TOP_DEGREE,
    parameter int P_COS_TOP   = COSINE_TOP_DEGREE
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire logic  i_valid,
    output logic       o_ready,
    output t_item      o_item,
    output logic       o_valid,
    input  wire logic  i_ready
);

    localparam int N_SIN = 2 * P_STEP + 1;
    localparam int N_COS = 2 * P_STEP;
    localparam longint unsigned D_SIN = longint'(N_SIN) * longint'(N_SIN - 1);
    localparam longint unsigned D_COS = longint'(N_COS) * longint'(N_COS - 1);
    localparam logic [MAG_W-1:0] RECIP_SIN = MAG_W'(((64'd1 << FRAC) + D_SIN / 2) / D_SIN);
    localparam logic [MAG_W-1:0] RECIP_COS = MAG_W'(((64'd1 << FRAC) + D_COS / 2) / D_COS);
    localparam bit ACT_SIN = (N_SIN <= P_SINE_TOP);
    localparam bit ACT_COS = (N_COS <= P_COS_TOP);

    logic ld_a, ld_b, ld_c, ld_d;
    logic r_a_v, r_b_v, r_c_v, r_d_v;
    logic r_a_act, r_b_act, r_c_act, r_d_act;
    logic n_act;
    t_item n_a, r_a, r_b, r_c, r_d;
    logic [MAG_W-1:0] prod1, prod2, recip;

    assign ld_d = !r_d_v || i_ready;
    assign ld_c = !r_c_v || ld_d;
    assign ld_b = !r_b_v || ld_c;
    assign ld_a = !r_a_v || ld_b;
    assign o_ready = ld_a;

    always_comb begin
        n_act = (i_item.cmd == CMD_SINE) ? ACT_SIN : ACT_COS;
        n_a   = i_item;
        if (n_act && i_item.pending) begin
            n_a.sum     = i_item.sum + signed_term(i_item.sign, i_item.mag);
            n_a.pending = 1'b0;
        end
    end

    tss_mul u_mul_x2 (
        .i_clk    (i_clk),
        .i_en_pp  (ld_a),
        .i_en_rnd (ld_b),
        .i_a      (i_item.mag),
        .i_b      (i_item.x2),
        .o_p      (prod1)
    );

    assign recip = (r_b.cmd == CMD_SINE) ? RECIP_SIN : RECIP_COS;

    tss_mul u_mul_recip (
        .i_clk    (i_clk),
        .i_en_pp  (ld_c),
        .i_en_rnd (ld_d),
        .i_a      (prod1),
        .i_b      (recip),
        .o_p      (prod2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (ld_a) r_a_v <= i_valid;
            if (ld_b) r_b_v <= r_a_v;
            if (ld_c) r_c_v <= r_b_v;
            if (ld_d) r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a     <= n_a;
            r_a_act <= n_act;
        end
        if (ld_b) begin
            r_b     <= r_a;
            r_b_act <= r_a_act;
        end
        if (ld_c) begin
            r_c     <= r_b;
            r_c_act <= r_b_act;
        end
        if (ld_d) begin
            r_d     <= r_c;
            r_d_act <= r_c_act;
        end
    end

    // Past the top degree, pass the word through untouched.
    always_comb begin
        o_item = r_d;
        if (r_d_act) begin
            o_item.mag     = prod2;
            o_item.sign    = !r_d.sign;
            o_item.pending = 1'b1;
        end
    end

    assign o_valid = r_d_v;

endmodule

`default_nettype wire

FILE: sv/tss_back.sv
// Back end: fold the last term, round to Q2.30 and saturate into the
// output register. Uses tss_pkg and tss_out_if.
`default_nettype none

module tss_back import tss_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire logic  i_valid,
    output logic       o_ready,
    tss_out_if.source  o_word
);

    logic ld_e, ld_f;
    logic r_e_v, r_f_v;
    logic signed [SUM_W-1:0] n_e_sum, r_e_sum, rnd, q;
    logic [SUM_W-RESULT_W:0] hi;
    logic signed [RESULT_W-1:0] n_f_result, r_f_result;

    assign ld_f = !r_f_v || o_word.ready;
    assign ld_e = !r_e_v || ld_f;
    assign o_ready = ld_e;

    assign n_e_sum = i_item.pending ? i_item.sum + signed_term(i_item.sign, i_item.mag)
                                    : i_item.sum;

    // Round half up, then clamp to the result range.
    always_comb begin
        rnd = r_e_sum + $signed(SUM_W'(1) << (FRAC - RESULT_FRAC - 1));
        q   = rnd >>> (FRAC - RESULT_FRAC);
        hi  = q[SUM_W-1:RESULT_W-1];
        if ((&hi) || !(|hi)) begin
            n_f_result = q[RESULT_W-1:0];
        end else if (q[SUM_W-1]) begin
            n_f_result = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
            n_f_result = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (ld_e) r_e_v <= i_valid;
            if (ld_f) r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_e) r_e_sum    <= n_e_sum;
        if (ld_f) r_f_result <= n_f_result;
    end

    assign o_word.valid  = r_f_v;
    assign o_word.result = r_f_result;

endmodule

`default_nettype wire

FILE: sv/taylor_sine_cosine_top.sv
// Taylor-series sine/cosine. Each input word holds a command (0 sine,
// 1 cosine) and a Q4.27 angle in radians; each output word is one signed
// Q2.30 result, saturated. The block is fully pipelined and takes one word
// per clock while the output is not stalled. The pipeline has NSTEP series
// steps, NSTEP being the larger of (SINE_TOP_DEGREE - 1) / 2 and
// COSINE_TOP_DEGREE / 2. Its depth is set by the chain of multipliers: x^2 takes
// one multiplication and every series term two, each split into 23-bit
// partial products and spread over a partial-product stage and a
// sum-and-round stage, plus one reduction stage and two output stages.
// Every stage holds its word when the next one is full and fills when it is
// empty, so bubbles close up under back-pressure and nothing is dropped.
// Depends on tss_pkg, tss_in_if, tss_out_if, tss_front, tss_step, tss_back.
`default_nettype none

module taylor_sine_cosine_top import tss_pkg::*; #(
    parameter int SINE_TOP_DEGREE   = tss_pkg::SINE_TOP_DEGREE,
    parameter int COSINE_TOP_DEGREE = tss_pkg::COSINE_TOP_DEGREE
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tss_in_if.sink    i_word,
    tss_out_if.source o_word
);

    localparam int NSTEP_SIN = (SINE_TOP_DEGREE - 1) / 2;
    localparam int NSTEP_COS = COSINE_TOP_DEGREE / 2;
    localparam int NSTEP     = (NSTEP_SIN > NSTEP_COS) ? NSTEP_SIN : NSTEP_COS;

    t_item          chain_item [NSTEP+1];
    logic [NSTEP:0] chain_v;
    logic [NSTEP:0] chain_rdy;

    tss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .o_item  (chain_item[0]),
        .o_valid (chain_v[0]),
        .i_ready (chain_rdy[0])
    );

    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        tss_step #(
            .P_STEP     (k),
            .P_SINE_TOP (SINE_TOP_DEGREE),
            .P_COS_TOP  (COSINE_TOP_DEGREE)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (chain_item[k-1]),
            .i_valid (chain_v[k-1]),
            .o_ready (chain_rdy[k-1]),
            .o_item  (chain_item[k]),
            .o_valid (chain_v[k]),
            .i_ready (chain_rdy[k])
        );
    end

    tss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (chain_item[NSTEP]),
        .i_valid (chain_v[NSTEP]),
        .o_ready (chain_rdy[NSTEP]),
        .o_word  (o_word)
    );

    // A fresh word has no pending term and a bounded x^2.
    a_front_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_v[0] |-> (!chain_item[0].pending && chain_item[0].x2 < X2_LIMIT))
        else $error("front word carries a pending term or x^2 out of range");

    // A reduced sine angle never exceeds pi in magnitude.
    a_front_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_v[0] && chain_item[0].cmd == CMD_SINE)
            |-> (chain_item[0].mag <= MAG_W'(PI_Q)))
        else $error("range reduction left the angle outside [-pi, pi]");

    // A word stalled at the last step holds until the back end takes it.
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_v[NSTEP] && !chain_rdy[NSTEP])
            |=> (chain_v[NSTEP] && $stable(chain_item[NSTEP])))
        else $error("word at the last series step changed while stalled");

endmodule

`default_nettype wire

FILE: dv/taylor_sine_cosine_top_tb.sv
// Self-checking testbench for taylor_sine_cosine_top: directed and random angles for
// sine and cosine, each result checked against a fixed-point series predictor.
// Depends on tss_pkg, tss_in_if, tss_out_if and the RTL of the block.
module taylor_sine_cosine_top_tb import tss_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 25;
    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 300;
    localparam logic signed [ANGLE_W-1:0] PI_BELOW = 32'sh1921FB54;  // last angle kept as is
    localparam logic signed [ANGLE_W-1:0] PI_ABOVE = 32'sh1921FB55;  // first angle wrapped

    typedef struct {
        t_cmd                      cmd;
        logic signed [ANGLE_W-1:0] angle;
        bit                        drain;  // hold until every result is back
    } t_angle_word;

    typedef struct {
        t_cmd                       cmd;
        logic signed [RESULT_W-1:0] value;
    } t_due_result;

    logic i_clk;
    logic i_rst_n;

    tss_in_if  in_word();
    tss_out_if out_word();

    taylor_sine_cosine_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (in_word),
        .o_word  (out_word)
    );

    t_angle_word angle_queue[$];
    t_due_result results_due[$];
    int          words_taken;
    int          words_in_flight;
    int          results_checked;
    int          sines_checked;
    int          cosines_checked;
    int          fail_count;
    int          hold_left;
    bit          hold_done;
    int          cycle_count;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Exact product of two Q.40 values, rounded to nearest with ties away from zero.
    function automatic longint series_mul(longint a, longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        longint       m;
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod + (128'd1 << (FRAC - 1));
        m    = longint'({2'b00, prod[FRAC+61:FRAC]});
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint factorial_recip(int n);
        longint d;
        d = longint'(n) * (n - 1);
        return ((longint'(1) << FRAC) + d / 2) / d;
    endfunction

    function automatic logic signed [RESULT_W-1:0] taylor_value(t_cmd cmd,
                                                               logic signed [ANGLE_W-1:0] angle);
        longint x;
        longint x2;
        longint term;
        longint total;
        longint rounded;
        x = longint'(angle) * (longint'(1) << ANGLE_SHIFT);
        while (x < -longint'(PI_Q))
            x = x + longint'(TWO_PI_Q);
        while (x > longint'(PI_Q))
            x = x - longint'(TWO_PI_Q);
        x2 = series_mul(x, x);
        if (cmd == CMD_SINE) begin
            term  = x;
            total = x;
            for (int n = 3; n <= SINE_TOP_DEGREE; n += 2) begin
                term  = -series_mul(series_mul(term, x2), factorial_recip(n));
                total = total + term;
            end
        end else begin
            term  = longint'(1) << FRAC;
            total = term;
            for (int n = 2; n <= COSINE_TOP_DEGREE; n += 2) begin
                term  = -series_mul(series_mul(term, x2), factorial_recip(n));
                total = total + term;
            end
        end
        // Round Q.40 to Q.30 with ties toward plus infinity, then saturate.
        rounded = (total + (longint'(1) << (FRAC - 31))) >>> (FRAC - RESULT_FRAC);
        if (rounded > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (rounded < longint'(32'sh80000000))
            return 32'sh80000000;
        return RESULT_W'(rounded);
    endfunction

    // Three idling phases by words taken: sender-light, receiver-light, none.
    function automatic int idle_pct(bit receiver_side);
        if (words_taken < RANDOM_WORDS / 3)
            return receiver_side ? 45 : 23;
        if (words_taken < 2 * RANDOM_WORDS / 3)
            return receiver_side ? 23 : 45;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_angle_word next_word;
        if (!i_rst_n) begin
            in_word.valid <= 1'b0;
        end else if (!in_word.valid || in_word.ready) begin
            if (angle_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0) &&
                !(angle_queue[0].drain && (words_in_flight != 0 || in_word.valid))) begin
                next_word        = angle_queue.pop_front();
                in_word.valid   <= 1'b1;
                in_word.command <= next_word.cmd;
                in_word.angle   <= next_word.angle;
            end else begin
                in_word.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_checked >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_due_result due;
        int          took;
        int          gave;
        if (!i_rst_n) begin
            out_word.ready  <= 1'b0;
            words_taken     <= 0;
            words_in_flight <= 0;
            results_checked <= 0;
        end else begin
            took = (in_word.valid && in_word.ready) ? 1 : 0;
            gave = (out_word.valid && out_word.ready) ? 1 : 0;
            if (gave != 0) begin
                if (results_due.size() == 0) begin
                    $error("result: expected none, actual %h", out_word.result);
                    fail_count++;
                end else begin
                    due = results_due.pop_front();
                    if (out_word.result !== due.value) begin
                        $error("result: expected %h, actual %h (%s)", due.value,
                               out_word.result, due.cmd.name());
                        fail_count++;
                    end
                    if (due.cmd == CMD_SINE)
                        sines_checked++;
                    else
                        cosines_checked++;
                end
            end
            if (took != 0) begin
                due.cmd   = t_cmd'(in_word.command);
                due.value = taylor_value(due.cmd, in_word.angle);
                results_due.push_back(due);
            end
            words_taken     <= words_taken + took;
            words_in_flight <= words_in_flight + took - gave;
            results_checked <= results_checked + gave;
            out_word.ready  <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("taylor_sine_cosine_top_tb failed");
            $finish;
        end
    end

    initial begin
        logic signed [ANGLE_W-1:0] edge_angles[12];
        t_angle_word               word;
        longint                    base;
        int                        kind;
        i_rst_n          = 1'b0;
        in_word.valid    = 1'b0;
        in_word.command  = 1'b0;
        in_word.angle    = '0;
        out_word.ready   = 1'b0;
        fail_count       = 0;
        sines_checked    = 0;
        cosines_checked  = 0;
        cycle_count      = 0;

        // Field extremes, both sides of the pi wrap, pi/2, tiny angles, the 3*pi region.
        edge_angles = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, PI_BELOW, PI_ABOVE,
                        -PI_BELOW, -PI_ABOVE, 32'sh0C90FDAA, 32'sh1, -32'sh1,
                        32'sh4B65F1FC, -32'sh4B65F1FC};
        foreach (edge_angles[i]) begin
            for (int c = 0; c < 2; c++) begin
                word.cmd   = t_cmd'(c);
                word.angle = edge_angles[i];
                word.drain = 1'b0;
                angle_queue.push_back(word);
            end
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            kind       = $urandom_range(9);
            word.cmd   = t_cmd'($urandom_range(1));
            word.drain = (i == 0 || i == 500 || i == 900);
            if (kind < 3) begin
                word.angle = $urandom();
            end else if (kind < 7) begin
                word.angle = ANGLE_W'(longint'($urandom_range(2 * PI_BELOW)) - PI_BELOW);
            end else if (kind < 9) begin
                // Near a multiple of pi, where reduction wraps or stops.
                base       = (longint'($urandom_range(10)) - 5) * PI_BELOW;
                word.angle = ANGLE_W'(base + longint'($urandom_range(8191)) - 4096);
            end else begin
                word.angle = ANGLE_W'(longint'($urandom_range(2047)) - 1024);
            end
            angle_queue.push_back(word);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (angle_queue.size() != 0 || in_word.valid || words_in_flight != 0 ||
               results_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);

        $display("Checked %0d sine and %0d cosine results: field extremes, pi wrap edges,",
                 sines_checked, cosines_checked);
        $display("random angles over the full range, under idling, a long hold-off and drains.");
        if (fail_count == 0) begin
            $display("taylor_sine_cosine_top_tb passed");
        end else begin
            $display("taylor_sine_cosine_top_tb failed");
        end
        $finish;
    end

endmodule
